/* rtl/pdi_pkg.sv */
`timescale 1ns / 1ps

package pdi_pkg;

  // ID1 group codes
  localparam logic [1:0] GRP_GND  = 2'd0;
  localparam logic [1:0] GRP_VCC  = 2'd1;
  localparam logic [1:0] GRP_PD   = 2'd2;
  localparam logic [1:0] GRP_OPEN = 2'd3;

  // device type codes
  localparam logic [3:0] T_NONE   = 4'd0;
  localparam logic [3:0] T_TOUCH  = 4'd10;
  localparam logic [3:0] T_TPOINT = 4'd11;
  localparam logic [3:0] T_3PART  = 4'd12;
  localparam logic [3:0] T_EXPLOD = 4'd13;
  localparam logic [3:0] T_UART   = 4'd14;

  // pin drive codes
  localparam logic [1:0] TX_LOW   = 2'd0;
  localparam logic [1:0] TX_HIGH  = 2'd1;
  localparam logic [1:0] TX_FLOAT = 2'd2;
  localparam logic [1:0] ID2_IN   = 2'd0;
  localparam logic [1:0] ID2_HIGH = 2'd1;
  localparam logic [1:0] ID2_LOW  = 2'd2;

  // probe sequencer phases
  localparam logic [3:0] PH_START     = 4'd0;
  localparam logic [3:0] PH_ID2_SAVE  = 4'd1;
  localparam logic [3:0] PH_ID2_CHECK = 4'd2;
  localparam logic [3:0] PH_TOUCH     = 4'd3;
  localparam logic [3:0] PH_ID1_CHECK = 4'd4;
  localparam logic [3:0] PH_ID1_FLOAT = 4'd5;
  localparam logic [3:0] PH_ID2_DRIVE = 4'd6;
  localparam logic [3:0] PH_ID1_SAVE  = 4'd7;
  localparam logic [3:0] PH_ID1_CMP   = 4'd8;
  localparam logic [3:0] PH_RX_HIGH   = 4'd9;
  localparam logic [3:0] PH_RX_LOW    = 4'd10;
  localparam logic [3:0] PH_FINISH    = 4'd11;

  localparam logic [7:0] MatchThresholdRst = 8'd20;
  localparam logic [7:0] MatchCntMax       = 8'd255;

  typedef struct packed {
    logic [3:0] phase;
    logic       saved;
    logic [1:0] grp;
    logic [3:0] ptype;
    logic [3:0] last_ptype;
    logic [7:0] match_cnt;
    logic [3:0] conn;
    logic [3:0] rep;
    logic [1:0] tx;
    logic       buf_en;
    logic [1:0] id2;
  } pdi_state_t;

  localparam pdi_state_t StateRst = '{
    phase:      PH_START,
    saved:      1'b0,
    grp:        GRP_OPEN,
    ptype:      T_NONE,
    last_ptype: T_NONE,
    match_cnt:  8'd0,
    conn:       T_NONE,
    rep:        T_NONE,
    tx:         TX_FLOAT,
    buf_en:     1'b0,
    id2:        ID2_IN
  };

  // 3x3 type table: row is the ID1 group (ground, supply, pull-down), col the ID2 response
  function automatic logic [3:0] type_lookup(input logic [1:0] grp, input logic [1:0] col);
    logic [3:0] t;
    begin
      t = 4'd0;
      case (grp)
        GRP_GND: t = 4'd1;
        GRP_VCC: t = 4'd4;
        GRP_PD:  t = 4'd7;
        default: t = 4'd0;
      endcase
      type_lookup = t + {2'b00, col};
    end
  endfunction

endpackage

/* rtl/port_device_identification_core.sv */
`timescale 1ns / 1ps

// Channel   Handshake                        Payload
// input     in_valid_i / in_ready_o          id1_level_i, id2_level_i, rx_level_i
// result    out_valid_o / out_ready_i        tx_drive_o, buffer_drive_o, id2_drive_o,
//                                            connected_type_o, type_changed_o, uart_select_o
// config    match_threshold_we_i             match_threshold_i
//
// One tick transaction in, one result out, registered in the cycle after it is accepted.
// Sustains one transaction per cycle unless a held result stalls it (see below):
// the sequencer update is a single pass between the state registers, which double as the result register.
// in_ready_o drops only while a result is held and out_ready_i is low.
// Reset puts the sequencer at the start of a probe with all pins floating.
module port_device_identification_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       id1_level_i,
  input  logic       id2_level_i,
  input  logic       rx_level_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] tx_drive_o,
  output logic       buffer_drive_o,
  output logic [1:0] id2_drive_o,
  output logic [3:0] connected_type_o,
  output logic       type_changed_o,
  output logic       uart_select_o,
  input  logic       match_threshold_we_i,
  input  logic [7:0] match_threshold_i
);

  pdi_pkg::pdi_state_t st_q, st_d;
  logic                changed_q, changed_d;
  logic                out_valid_q;
  logic [7:0]          threshold_q;
  logic                in_acc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  pdi_seq u_seq (
    .st_i        (st_q),
    .id1_i       (id1_level_i),
    .id2_i       (id2_level_i),
    .rx_i        (rx_level_i),
    .threshold_i (threshold_q),
    .st_o        (st_d),
    .changed_o   (changed_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= pdi_pkg::StateRst;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
      threshold_q <= pdi_pkg::MatchThresholdRst;
    end else begin
      if (match_threshold_we_i) threshold_q <= match_threshold_i;
      if (in_acc) begin
        st_q      <= st_d;
        changed_q <= changed_d;
      end
      if (in_acc) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign tx_drive_o       = st_q.tx;
  assign buffer_drive_o   = st_q.buf_en;
  assign id2_drive_o      = st_q.id2;
  assign connected_type_o = st_q.conn;
  assign type_changed_o   = changed_q;
  assign uart_select_o    = (st_q.conn == pdi_pkg::T_UART);

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase <= pdi_pkg::PH_FINISH)
    else $error("probe phase out of range");

  a_cnt_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.match_cnt != pdi_pkg::MatchCntMax)
    else $error("match counter reached saturation value");

  a_uart_buf_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uart_select_o |-> !buffer_drive_o)
    else $error("buffer enabled while muxed to UART");

  a_uart_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && uart_select_o |=> $stable(st_q.phase) && $stable(st_q.conn))
    else $error("sequencer moved after UART selection");

  a_changed_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> st_q.rep == st_q.conn)
    else $error("reported type out of step with connected type");

endmodule

/* rtl/pdi_seq.sv */
`timescale 1ns / 1ps

// One tick of the probe sequencer plus debounce of the connected type.
module pdi_seq (
  input  pdi_pkg::pdi_state_t st_i,
  input  logic                id1_i,
  input  logic                id2_i,
  input  logic                rx_i,
  input  logic [7:0]          threshold_i,
  output pdi_pkg::pdi_state_t st_o,
  output logic                changed_o
);

  logic [7:0] cnt_inc;

  assign cnt_inc = (st_i.match_cnt < pdi_pkg::MatchCntMax) ? st_i.match_cnt + 8'd1
                                                           : st_i.match_cnt;

  always_comb begin
    st_o      = st_i;
    changed_o = 1'b0;
    if (st_i.conn != pdi_pkg::T_UART) begin
      unique case (st_i.phase)
        pdi_pkg::PH_ID2_SAVE: begin
          st_o.saved = id2_i;
          st_o.tx    = pdi_pkg::TX_LOW;
          st_o.phase = pdi_pkg::PH_ID2_CHECK;
        end
        pdi_pkg::PH_ID2_CHECK: begin
          if (st_i.saved && !id2_i) begin
            st_o.ptype  = pdi_pkg::T_TOUCH;
            st_o.buf_en = 1'b1;
            st_o.tx     = pdi_pkg::TX_FLOAT;
            st_o.phase  = pdi_pkg::PH_TOUCH;
          end else if (!st_i.saved && id2_i) begin
            st_o.ptype = pdi_pkg::T_TPOINT;
            st_o.phase = pdi_pkg::PH_FINISH;
          end else begin
            st_o.saved = id1_i;
            st_o.tx    = pdi_pkg::TX_HIGH;
            st_o.phase = pdi_pkg::PH_ID1_CHECK;
          end
        end
        pdi_pkg::PH_TOUCH: begin
          st_o.phase = pdi_pkg::PH_FINISH;
        end
        pdi_pkg::PH_ID1_CHECK: begin
          if (st_i.saved && id1_i) begin
            st_o.grp   = pdi_pkg::GRP_VCC;
            st_o.phase = pdi_pkg::PH_ID2_DRIVE;
          end else if (!st_i.saved && !id1_i) begin
            st_o.grp   = pdi_pkg::GRP_GND;
            st_o.phase = pdi_pkg::PH_ID2_DRIVE;
          end else begin
            st_o.buf_en = 1'b1;
            st_o.tx     = pdi_pkg::TX_FLOAT;
            st_o.phase  = pdi_pkg::PH_ID1_FLOAT;
          end
        end
        pdi_pkg::PH_ID1_FLOAT: begin
          st_o.grp   = id1_i ? pdi_pkg::GRP_OPEN : pdi_pkg::GRP_PD;
          st_o.phase = pdi_pkg::PH_ID2_DRIVE;
        end
        pdi_pkg::PH_ID2_DRIVE: begin
          st_o.buf_en = 1'b1;
          st_o.tx     = pdi_pkg::TX_FLOAT;
          st_o.id2    = pdi_pkg::ID2_HIGH;
          st_o.phase  = pdi_pkg::PH_ID1_SAVE;
        end
        pdi_pkg::PH_ID1_SAVE: begin
          st_o.saved = id1_i;
          st_o.id2   = pdi_pkg::ID2_LOW;
          st_o.phase = pdi_pkg::PH_ID1_CMP;
        end
        pdi_pkg::PH_ID1_CMP: begin
          if (st_i.saved && !id1_i) begin
            if (st_i.grp == pdi_pkg::GRP_OPEN) st_o.ptype = pdi_pkg::T_3PART;
            st_o.phase = pdi_pkg::PH_FINISH;
          end else if (!st_i.saved && id1_i) begin
            st_o.ptype = pdi_pkg::T_EXPLOD;
            st_o.phase = pdi_pkg::PH_FINISH;
          end else begin
            st_o.tx     = pdi_pkg::TX_HIGH;
            st_o.buf_en = 1'b0;
            st_o.id2    = pdi_pkg::ID2_HIGH;
            st_o.phase  = pdi_pkg::PH_RX_HIGH;
          end
        end
        pdi_pkg::PH_RX_HIGH: begin
          if (rx_i) begin
            st_o.id2   = pdi_pkg::ID2_LOW;
            st_o.phase = pdi_pkg::PH_RX_LOW;
          end else begin
            // open group with the ID2 pull missing is a UART device
            st_o.ptype = (st_i.grp != pdi_pkg::GRP_OPEN) ? pdi_pkg::type_lookup(st_i.grp, 2'd0)
                                                         : pdi_pkg::T_UART;
            st_o.phase = pdi_pkg::PH_FINISH;
          end
        end
        pdi_pkg::PH_RX_LOW: begin
          if (st_i.grp != pdi_pkg::GRP_OPEN)
            st_o.ptype = pdi_pkg::type_lookup(st_i.grp, rx_i ? 2'd1 : 2'd2);
          st_o.phase = pdi_pkg::PH_FINISH;
        end
        pdi_pkg::PH_FINISH: begin
          st_o.id2    = pdi_pkg::ID2_IN;
          st_o.tx     = pdi_pkg::TX_LOW;
          st_o.buf_en = 1'b0;
          if (st_i.ptype == st_i.last_ptype) begin
            if (cnt_inc >= threshold_i) begin
              st_o.conn      = st_i.ptype;
              st_o.match_cnt = cnt_inc - 8'd1;
            end else begin
              st_o.match_cnt = cnt_inc;
            end
          end else begin
            st_o.match_cnt = 8'd0;
          end
          st_o.last_ptype = st_i.ptype;
          st_o.phase      = pdi_pkg::PH_START;
        end
        default: begin
          st_o.ptype  = pdi_pkg::T_NONE;
          st_o.grp    = pdi_pkg::GRP_OPEN;
          st_o.tx     = pdi_pkg::TX_HIGH;
          st_o.buf_en = 1'b0;
          st_o.id2    = pdi_pkg::ID2_IN;
          st_o.phase  = pdi_pkg::PH_ID2_SAVE;
        end
      endcase
    end

    if (st_o.conn != st_i.rep) begin
      st_o.rep  = st_o.conn;
      changed_o = 1'b1;
      if (st_o.conn == pdi_pkg::T_UART) st_o.buf_en = 1'b0;
    end
  end

endmodule
